// ----- sv/ttcb_pkg.sv -----
// Shared types, constants and the 5x8 font table of the text-to-column-bytes unit.
// No dependencies; every module of the unit imports this package.
package ttcb_pkg;

  // Column where a newline stops padding (range 8 to 127)
  localparam logic [7:0] LINE_END     = 8'd127;
  localparam logic [7:0] NEWLINE_CODE = 8'd10;
  localparam logic [7:0] FIRST_CODE   = 8'd32;
  localparam logic [7:0] COL_ADVANCE  = 8'd6;
  localparam logic [7:0] CURSOR_MAX   = 8'd255;
  localparam logic [3:0] CMD_COL_HIGH = 4'h1;
  localparam logic [7:0] BLANK_BYTE   = 8'h00;
  localparam logic [1:0] CHAR_BEAT_LAST = 2'd2;

  // Result source chosen for the output register
  typedef enum logic [2:0] {
    SEL_CHAR = 3'b001,
    SEL_NL   = 3'b010,
    SEL_SETC = 3'b100
  } sel_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic latch;
    logic emit;
    sel_t sel;
  } cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic is_setc;
    logic is_nl;
    logic nl_none;
    logic out_free;
    logic beat_last;
    logic nl_last;
  } stat_t;

  // Glyph columns packed as {c0, c1, c2, c3, c4}
  function automatic logic [39:0] font_glyph(input logic [6:0] idx);
    logic [39:0] g;
    case (idx)
      7'd0:  g = 40'h0000000000;  7'd1:  g = 40'h005F000000;
      7'd2:  g = 40'h0007000700;  7'd3:  g = 40'h147F147F14;
      7'd4:  g = 40'h242A7F2A12;  7'd5:  g = 40'h2313086462;
      7'd6:  g = 40'h3649552250;  7'd7:  g = 40'h0005030000;
      7'd8:  g = 40'h1C22410000;  7'd9:  g = 40'h41221C0000;
      7'd10: g = 40'h082A1C2A08;  7'd11: g = 40'h08083E0808;
      7'd12: g = 40'hA060000000;  7'd13: g = 40'h0808080808;
      7'd14: g = 40'h6060000000;  7'd15: g = 40'h2010080402;
      7'd16: g = 40'h3E5149453E;  7'd17: g = 40'h00427F4000;
      7'd18: g = 40'h6251494946;  7'd19: g = 40'h2241494936;
      7'd20: g = 40'h1814127F10;  7'd21: g = 40'h2745454539;
      7'd22: g = 40'h3C4A494930;  7'd23: g = 40'h0171090503;
      7'd24: g = 40'h3649494936;  7'd25: g = 40'h064949291E;
      7'd26: g = 40'h0036360000;  7'd27: g = 40'h00AC6C0000;
      7'd28: g = 40'h0814224100;  7'd29: g = 40'h1414141414;
      7'd30: g = 40'h4122140800;  7'd31: g = 40'h0201510906;
      7'd32: g = 40'h324979413E;  7'd33: g = 40'h7E0909097E;
      7'd34: g = 40'h7F49494936;  7'd35: g = 40'h3E41414122;
      7'd36: g = 40'h7F4141221C;  7'd37: g = 40'h7F49494941;
      7'd38: g = 40'h7F09090901;  7'd39: g = 40'h3E41415172;
      7'd40: g = 40'h7F0808087F;  7'd41: g = 40'h417F410000;
      7'd42: g = 40'h2040413F01;  7'd43: g = 40'h7F08142241;
      7'd44: g = 40'h7F40404040;  7'd45: g = 40'h7F020C027F;
      7'd46: g = 40'h7F0408107F;  7'd47: g = 40'h3E4141413E;
      7'd48: g = 40'h7F09090906;  7'd49: g = 40'h3E4151215E;
      7'd50: g = 40'h7F09192946;  7'd51: g = 40'h2649494932;
      7'd52: g = 40'h01017F0101;  7'd53: g = 40'h3F4040403F;
      7'd54: g = 40'h1F2040201F;  7'd55: g = 40'h3F4038403F;
      7'd56: g = 40'h6314081463;  7'd57: g = 40'h0304780403;
      7'd58: g = 40'h6151494543;  7'd59: g = 40'h7F41410000;
      7'd60: g = 40'h0204081020;  7'd61: g = 40'h41417F0000;
      7'd62: g = 40'h0402010204;  7'd63: g = 40'h8080808080;
      7'd64: g = 40'h0102040000;  7'd65: g = 40'h2054545478;
      7'd66: g = 40'h7F48444438;  7'd67: g = 40'h3844442800;
      7'd68: g = 40'h384444487F;  7'd69: g = 40'h3854545418;
      7'd70: g = 40'h087E090200;  7'd71: g = 40'h18A4A4A47C;
      7'd72: g = 40'h7F08040478;  7'd73: g = 40'h007D000000;
      7'd74: g = 40'h80847D0000;  7'd75: g = 40'h7F10284400;
      7'd76: g = 40'h417F400000;  7'd77: g = 40'h7C04180478;
      7'd78: g = 40'h7C08047C00;  7'd79: g = 40'h3844443800;
      7'd80: g = 40'hFC24241800;  7'd81: g = 40'h182424FC00;
      7'd82: g = 40'h007C080400;  7'd83: g = 40'h4854542400;
      7'd84: g = 40'h047F440000;  7'd85: g = 40'h3C40407C00;
      7'd86: g = 40'h1C2040201C;  7'd87: g = 40'h3C4030403C;
      7'd88: g = 40'h4428102844;  7'd89: g = 40'h1CA0A07C00;
      7'd90: g = 40'h4464544C44;  7'd91: g = 40'h0836410000;
      7'd92: g = 40'h007F000000;  7'd93: g = 40'h4136080000;
      7'd94: g = 40'h0201010201;  7'd95: g = 40'h0205050200;
      default: g = 40'h0000000000;
    endcase
    return g;
  endfunction

endpackage

// ----- sv/ttcb_ctrl.sv -----
// Controller state machine of the text-to-column-bytes unit.
// Depends on ttcb_pkg for command and status types.
module ttcb_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  ttcb_pkg::stat_t st,
  output ttcb_pkg::cmd_t  cmd
);
  import ttcb_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_SETC = 4'b0010,
    S_CHAR = 4'b0100,
    S_NL   = 4'b1000
  } state_t;

  state_t state, state_next;

  // Decode state into commands and next state
  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    cmd.latch  = 1'b0;
    cmd.emit   = 1'b0;
    cmd.sel    = SEL_CHAR;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.latch = 1'b1;
          if (st.is_setc) state_next = S_SETC;
          else if (st.is_nl) state_next = st.nl_none ? S_IDLE : S_NL;
          else state_next = S_CHAR;
        end
      end
      S_SETC: begin
        cmd.sel = SEL_SETC;
        if (st.out_free) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_CHAR: begin
        cmd.sel = SEL_CHAR;
        if (st.out_free) begin
          cmd.emit = 1'b1;
          if (st.beat_last) state_next = S_IDLE;
        end
      end
      S_NL: begin
        cmd.sel = SEL_NL;
        if (st.out_free) begin
          cmd.emit = 1'b1;
          if (st.nl_last) state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Hold state
  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

endmodule

// ----- sv/ttcb_dp.sv -----
// Datapath of the text-to-column-bytes unit: cursor, item registers, font lookup
// and output register. Depends on ttcb_pkg for types, constants and font table.
module ttcb_dp (
  input  logic            clk,
  input  logic            rst,
  input  logic            mode,
  input  logic [7:0]      char_code,
  input  logic [6:0]      column,
  input  ttcb_pkg::cmd_t  cmd,
  output ttcb_pkg::stat_t st,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [7:0]      byte_first,
  output logic [7:0]      byte_second,
  output logic            second_valid,
  output logic            is_command,
  output logic            last
);
  import ttcb_pkg::*;

  logic [7:0]  cursor;
  logic [6:0]  glyph_idx;
  logic [6:0]  col_q;
  logic [6:0]  rem;
  logic [1:0]  beat;
  logic [8:0]  cursor_sum;
  logic        printable;
  logic [39:0] glyph;
  logic [7:0]  b0_next, b1_next;
  logic        sv_next, cmd_next, last_next;

  assign printable  = (char_code[7] == 1'b0) && (char_code[6:5] != 2'b00);
  assign cursor_sum = {1'b0, cursor} + {1'b0, COL_ADVANCE};

  // Report item kind and progress
  assign st.is_setc   = mode;
  assign st.is_nl     = (char_code == NEWLINE_CODE);
  assign st.nl_none   = (cursor >= LINE_END);
  assign st.out_free  = !out_valid || out_ready;
  assign st.beat_last = (beat == CHAR_BEAT_LAST);
  assign st.nl_last   = (rem <= 7'd2);

  // Set or advance the cursor on accept
  always_ff @(posedge clk) begin
    if (rst) begin
      cursor <= '0;
    end else if (cmd.latch) begin
      if (mode) cursor <= {1'b0, column};
      else if (st.is_nl) begin
        if (!st.nl_none) cursor <= LINE_END;
      end else cursor <= cursor_sum[8] ? CURSOR_MAX : cursor_sum[7:0];
    end
  end

  // Latch item fields on accept, then step beat and remaining pad count
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      glyph_idx <= printable ? 7'(char_code - FIRST_CODE) : 7'd0;
      col_q     <= column;
      rem       <= 7'(LINE_END - cursor);
      beat      <= 2'd0;
    end else if (cmd.emit) begin
      beat <= beat + 2'd1;
      rem  <= (rem >= 7'd2) ? rem - 7'd2 : rem - 7'd1;
    end
  end

  assign glyph = font_glyph(glyph_idx);

  // Select next result
  always_comb begin
    b0_next   = BLANK_BYTE;
    b1_next   = BLANK_BYTE;
    sv_next   = 1'b1;
    cmd_next  = 1'b0;
    last_next = 1'b0;
    unique case (cmd.sel)
      SEL_CHAR: begin
        last_next = (beat == CHAR_BEAT_LAST);
        case (beat)
          2'd0: begin
            b0_next = glyph[39:32];
            b1_next = glyph[31:24];
          end
          2'd1: begin
            b0_next = glyph[23:16];
            b1_next = glyph[15:8];
          end
          default: begin
            b0_next = glyph[7:0];
            b1_next = BLANK_BYTE;
          end
        endcase
      end
      SEL_NL: begin
        sv_next   = (rem >= 7'd2);
        last_next = (rem <= 7'd2);
      end
      SEL_SETC: begin
        b0_next   = {CMD_COL_HIGH, 1'b0, col_q[6:4]};
        b1_next   = {4'h0, col_q[3:0]};
        cmd_next  = 1'b1;
        last_next = 1'b1;
      end
      default: begin
        sv_next = 1'b0;
      end
    endcase
  end

  // Hold output register until transfer
  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (cmd.emit) out_valid <= 1'b1;
    else if (out_ready) out_valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      byte_first   <= b0_next;
      byte_second  <= b1_next;
      second_valid <= sv_next;
      is_command   <= cmd_next;
      last         <= last_next;
    end
  end

  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> (!out_valid || out_ready))
    else $error("result loaded over an untaken result");

  a_nl_rem: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit && cmd.sel == SEL_NL) |-> (rem != 7'd0))
    else $error("newline pad emitted with nothing left");

  a_setc_last: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit && cmd.sel == SEL_SETC) |=> (out_valid && last && is_command))
    else $error("set-column result not marked last command");

  a_latch_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.latch |-> !cmd.emit)
    else $error("accept and result load in the same cycle");

endmodule

// ----- sv/text_to_column_bytes_unit.sv -----
// Top level of the text-to-column-bytes unit: controller plus datapath.
// Depends on ttcb_pkg, ttcb_ctrl and ttcb_dp.
//
//   channel | handshake           | payload
//   in      | in_valid, in_ready   | mode, char_code, column
//   out     | out_valid, out_ready | byte_first, byte_second, second_valid, is_command, last
//
// One item is taken at a time: it is accepted in the idle state, then its results follow.
// A character gives three results, a set-column one, a newline one per two pad columns.
// The single output register passes one result per cycle while the output is not stalled.
// Reset (rst, synchronous) clears the cursor column, the output valid flag and the controller.
// A stalled output holds the sequence; nothing is dropped.
module text_to_column_bytes_unit (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       mode,
  input  logic [7:0] char_code,
  input  logic [6:0] column,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] byte_first,
  output logic [7:0] byte_second,
  output logic       second_valid,
  output logic       is_command,
  output logic       last
);
  import ttcb_pkg::*;

  cmd_t  cmd;
  stat_t st;

  ttcb_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .st       (st),
    .cmd      (cmd)
  );

  ttcb_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .mode         (mode),
    .char_code    (char_code),
    .column       (column),
    .cmd          (cmd),
    .st           (st),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .byte_first   (byte_first),
    .byte_second  (byte_second),
    .second_valid (second_valid),
    .is_command   (is_command),
    .last         (last)
  );

endmodule
